[rtl/pdsd_pkg.sv]
package pdsd_pkg;

    // Fixed-point constants: positions Q1.15, gains Q4.12, duty in units of 2^-27
    localparam logic signed [16:0] DEAD_LSB   = 17'sd327;
    localparam logic signed [37:0] ONE_Q27    = 38'sd134217728;
    localparam logic [11:0]        X_LOW_MAX  = 12'd573;
    localparam logic [11:0]        X_HIGH_MIN = 12'd3687;
    localparam logic [11:0]        Y_LOW_MAX  = 12'd409;
    localparam logic [11:0]        Y_HIGH_MIN = 12'd3277;
    localparam logic [15:0]        PERIOD_RST = 16'd1000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TRACKING = 3'd0,
        REG_TARGET_X = 3'd1,
        REG_TARGET_Y = 3'd2,
        REG_KP_X     = 3'd3,
        REG_KD_X     = 3'd4,
        REG_KP_Y     = 3'd5,
        REG_KD_Y     = 3'd6,
        REG_PERIOD   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        tracking;
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic [15:0] kp_x;
        logic [15:0] kd_x;
        logic [15:0] kp_y;
        logic [15:0] kd_y;
        logic [15:0] period;
    } t_cfg;

    // Datapath operations, one per controller step
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_MUL_P  = 3'd1,
        OP_MUL_D  = 3'd2,
        OP_DUTY   = 3'd3,
        OP_MUL_LO = 3'd4,
        OP_MUL_HI = 3'd5,
        OP_CMP    = 3'd6
    } t_op;

    typedef struct packed {
        logic load_in;
        t_op  op;
        logic axis;
        logic load_out;
    } t_dp_cmd;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_MUL_P  = 3'd1,
        ST_MUL_D  = 3'd2,
        ST_DUTY   = 3'd3,
        ST_MUL_LO = 3'd4,
        ST_MUL_HI = 3'd5,
        ST_CMP    = 3'd6,
        ST_DONE   = 3'd7
    } t_state;

endpackage

[rtl/pdsd_ctrl.sv]
module pdsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output pdsd_pkg::t_dp_cmd o_cmd
);

    pdsd_pkg::t_state r_state, n_state;
    logic             r_axis, n_axis;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            pdsd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = pdsd_pkg::ST_MUL_P;
                    n_axis  = 1'b0;
                end
            end
            pdsd_pkg::ST_MUL_P:  n_state = pdsd_pkg::ST_MUL_D;
            pdsd_pkg::ST_MUL_D:  n_state = pdsd_pkg::ST_DUTY;
            pdsd_pkg::ST_DUTY:   n_state = pdsd_pkg::ST_MUL_LO;
            pdsd_pkg::ST_MUL_LO: n_state = pdsd_pkg::ST_MUL_HI;
            pdsd_pkg::ST_MUL_HI: n_state = pdsd_pkg::ST_CMP;
            pdsd_pkg::ST_CMP: begin
                if (r_axis) begin
                    n_state = pdsd_pkg::ST_DONE;
                end else begin
                    n_state = pdsd_pkg::ST_MUL_P;
                    n_axis  = 1'b1;
                end
            end
            pdsd_pkg::ST_DONE: begin
                if (out_free) n_state = pdsd_pkg::ST_IDLE;
            end
            default: n_state = pdsd_pkg::ST_IDLE;
        endcase
    end

    // Outputs: datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.axis     = r_axis;
        o_cmd.op       = pdsd_pkg::OP_NONE;
        unique case (r_state)
            pdsd_pkg::ST_IDLE:   o_cmd.load_in = i_in_valid;
            pdsd_pkg::ST_MUL_P:  o_cmd.op = pdsd_pkg::OP_MUL_P;
            pdsd_pkg::ST_MUL_D:  o_cmd.op = pdsd_pkg::OP_MUL_D;
            pdsd_pkg::ST_DUTY:   o_cmd.op = pdsd_pkg::OP_DUTY;
            pdsd_pkg::ST_MUL_LO: o_cmd.op = pdsd_pkg::OP_MUL_LO;
            pdsd_pkg::ST_MUL_HI: o_cmd.op = pdsd_pkg::OP_MUL_HI;
            pdsd_pkg::ST_CMP:    o_cmd.op = pdsd_pkg::OP_CMP;
            pdsd_pkg::ST_DONE:   o_cmd.load_out = out_free;
            default:             o_cmd.op = pdsd_pkg::OP_NONE;
        endcase
    end

    // Output item valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == pdsd_pkg::ST_DONE && out_free) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdsd_pkg::ST_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != pdsd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/pdsd_datapath.sv]
module pdsd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdsd_pkg::t_dp_cmd i_cmd,
    input  pdsd_pkg::t_cfg    i_cfg,
    input  logic [15:0]       i_pos_x,
    input  logic [15:0]       i_pos_y,
    input  logic [11:0]       i_end_x,
    input  logic [11:0]       i_end_y,
    output logic [15:0]       o_compare_x,
    output logic              o_dir_x,
    output logic [15:0]       o_compare_y,
    output logic              o_dir_y
);

    // Sample and state registers
    logic [15:0]        r_pos_x, r_pos_y, r_prev_x, r_prev_y;
    logic [11:0]        r_end_x, r_end_y;
    // Working registers
    logic signed [35:0] r_p, r_d;
    logic [26:0]        r_duty;
    logic               r_zero, r_full, r_dir;
    logic [31:0]        r_lo;
    logic [26:0]        r_hi;
    // Per-axis results and output registers
    logic [15:0]        r_cmp_x, r_cmp_y;
    logic               r_dir_x, r_dir_y;
    logic [15:0]        r_out_cmp_x, r_out_cmp_y;
    logic               r_out_dir_x, r_out_dir_y;

    // Axis selection
    logic [15:0]        pos, prev, tgt, kp, kd;
    logic [11:0]        endv, low_max, high_min;

    always_comb begin
        if (i_cmd.axis) begin
            pos      = r_pos_y;
            prev     = r_prev_y;
            tgt      = i_cfg.target_y;
            kp       = i_cfg.kp_y;
            kd       = i_cfg.kd_y;
            endv     = r_end_y;
            low_max  = pdsd_pkg::Y_LOW_MAX;
            high_min = pdsd_pkg::Y_HIGH_MIN;
        end else begin
            pos      = r_pos_x;
            prev     = r_prev_x;
            tgt      = i_cfg.target_x;
            kp       = i_cfg.kp_x;
            kd       = i_cfg.kd_x;
            endv     = r_end_x;
            low_max  = pdsd_pkg::X_LOW_MAX;
            high_min = pdsd_pkg::X_HIGH_MIN;
        end
    end

    // Error and velocity terms, exact 17-bit
    logic signed [16:0] err, diff;
    assign err  = $signed({pos[15], pos}) - $signed({tgt[15], tgt});
    assign diff = $signed({pos[15], pos}) - $signed({prev[15], prev});

    // Shared 18x18 signed multiplier
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;

    always_comb begin
        case (i_cmd.op)
            pdsd_pkg::OP_MUL_P: begin
                mul_a = $signed({err[16], err});
                mul_b = $signed({{2{kp[15]}}, kp});
            end
            pdsd_pkg::OP_MUL_D: begin
                mul_a = $signed({diff[16], diff});
                mul_b = $signed({{2{kd[15]}}, kd});
            end
            pdsd_pkg::OP_MUL_LO: begin
                mul_a = $signed({2'b00, r_duty[15:0]});
                mul_b = $signed({2'b00, i_cfg.period});
            end
            pdsd_pkg::OP_MUL_HI: begin
                mul_a = $signed({7'd0, r_duty[26:16]});
                mul_b = $signed({2'b00, i_cfg.period});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Duty decision: sign of P, dead band, end stops
    logic signed [37:0] p_ext, p_eff, d_ext, duty_sum, duty_fin;
    logic               p_pos, p_neg, dead, dir_fin;

    always_comb begin
        p_ext    = {{2{r_p[35]}}, r_p};
        d_ext    = {{2{r_d[35]}}, r_d};
        p_eff    = i_cfg.tracking ? -p_ext : p_ext;
        duty_sum = p_eff + d_ext;
        p_neg    = p_eff[37];
        p_pos    = !p_eff[37] && (p_eff != '0);
        dead     = (err <= pdsd_pkg::DEAD_LSB) && (err >= -pdsd_pkg::DEAD_LSB);
        if (dead) begin
            duty_fin = '0;
            dir_fin  = 1'b0;
        end else if (p_pos) begin
            duty_fin = pdsd_pkg::ONE_Q27 - duty_sum;
            dir_fin  = 1'b1;
        end else begin
            duty_fin = -duty_sum;
            dir_fin  = 1'b0;
        end
        // low end stop forbids driving further toward it
        if (endv <= low_max && p_pos) begin
            duty_fin = '0;
            dir_fin  = 1'b0;
        end
        // high end stop drives full duty back
        if (endv >= high_min && p_neg) begin
            duty_fin = pdsd_pkg::ONE_Q27;
            dir_fin  = 1'b1;
        end
    end

    // Compare value: floor(duty * period / 2^27), clipped to period
    logic [43:0] prod_sum;
    logic [16:0] quot;
    logic [15:0] cmp_val;

    always_comb begin
        prod_sum = {1'b0, r_hi, 16'd0} + {12'd0, r_lo};
        quot     = prod_sum[43:27];
        if (r_zero) begin
            cmp_val = '0;
        end else if (r_full || quot > {1'b0, i_cfg.period}) begin
            cmp_val = i_cfg.period;
        end else begin
            cmp_val = quot[15:0];
        end
    end

    // Sample capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_end_x <= i_end_x;
            r_end_y <= i_end_y;
        end
        case (i_cmd.op)
            pdsd_pkg::OP_MUL_P:  r_p <= mul_p;
            pdsd_pkg::OP_MUL_D:  r_d <= mul_p;
            pdsd_pkg::OP_DUTY: begin
                r_duty <= duty_fin[26:0];
                r_zero <= duty_fin[37] || (duty_fin == '0);
                r_full <= !duty_fin[37] && (duty_fin >= pdsd_pkg::ONE_Q27);
                r_dir  <= dir_fin;
            end
            pdsd_pkg::OP_MUL_LO: r_lo <= mul_p[31:0];
            pdsd_pkg::OP_MUL_HI: r_hi <= mul_p[26:0];
            pdsd_pkg::OP_CMP: begin
                if (i_cmd.axis) begin
                    r_cmp_y <= cmp_val;
                    r_dir_y <= r_dir;
                end else begin
                    r_cmp_x <= cmp_val;
                    r_dir_x <= r_dir;
                end
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out_cmp_x <= r_cmp_x;
            r_out_dir_x <= r_dir_x;
            r_out_cmp_y <= r_cmp_y;
            r_out_dir_y <= r_dir_y;
        end
    end

    // Previous positions: advance once the item's results are out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (i_cmd.load_out) begin
            r_prev_x <= r_pos_x;
            r_prev_y <= r_pos_y;
        end
    end

    assign o_compare_x = r_out_cmp_x;
    assign o_dir_x     = r_out_dir_x;
    assign o_compare_y = r_out_cmp_y;
    assign o_dir_y     = r_out_dir_y;

endmodule

[rtl/two_axis_pd_servo_drive.sv]
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_stall    i_pos_x, i_pos_y, i_end_x, i_end_y
// out       o_out_valid / i_out_stall  o_compare_x, o_dir_x, o_compare_y, o_dir_y
// cfg       i_cfg_we                   i_cfg_index, i_cfg_data
//
// An item is processed in six steps per axis (two products, duty decision,
// two partial products of duty * period, compare) on one shared 18x18
// multiplier; the output register is then loaded and the next item taken.
// Synchronous active-low reset clears control state and previous positions and
// returns configuration to reset values. A finished item waits in the output
// register while the next is accepted; it is replaced only once it is taken.
module two_axis_pd_servo_drive (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [11:0] i_end_x,
    input  logic [11:0] i_end_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_compare_x,
    output logic        o_dir_x,
    output logic [15:0] o_compare_y,
    output logic        o_dir_y,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    pdsd_pkg::t_cfg    r_cfg;
    pdsd_pkg::t_dp_cmd cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{tracking: 1'b0,
                       target_x: 16'd0,
                       target_y: 16'd0,
                       kp_x:     16'd0,
                       kd_x:     16'd0,
                       kp_y:     16'd0,
                       kd_y:     16'd0,
                       period:   pdsd_pkg::PERIOD_RST};
        end else if (i_cfg_we) begin
            unique case (pdsd_pkg::t_reg_idx'(i_cfg_index))
                pdsd_pkg::REG_TRACKING: r_cfg.tracking <= i_cfg_data[0];
                pdsd_pkg::REG_TARGET_X: r_cfg.target_x <= i_cfg_data;
                pdsd_pkg::REG_TARGET_Y: r_cfg.target_y <= i_cfg_data;
                pdsd_pkg::REG_KP_X:     r_cfg.kp_x     <= i_cfg_data;
                pdsd_pkg::REG_KD_X:     r_cfg.kd_x     <= i_cfg_data;
                pdsd_pkg::REG_KP_Y:     r_cfg.kp_y     <= i_cfg_data;
                pdsd_pkg::REG_KD_Y:     r_cfg.kd_y     <= i_cfg_data;
                pdsd_pkg::REG_PERIOD:   r_cfg.period   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pdsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    pdsd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_compare_x (o_compare_x),
        .o_dir_x     (o_dir_x),
        .o_compare_y (o_compare_y),
        .o_dir_y     (o_dir_y)
    );

endmodule
